>>> hw/rtl/bdsd_pkg.sv
// ----------------------------------------------------------------------------
// bdsd_pkg: shared types for the bounded deque search/delete unit
// Request and response transaction layouts, operation and status codes, and
// the per-cell control word.
// ----------------------------------------------------------------------------
package bdsd_pkg;

   typedef enum logic [1:0] {
      FN_INS_HEAD = 2'd0,
      FN_INS_TAIL = 2'd1,
      FN_DELETE   = 2'd2,
      FN_SEARCH   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_MISSING = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   localparam int VALUE_W = 32;
   localparam int POS_OUT_W = 4;
   localparam int CNT_OUT_W = 5;

   typedef struct packed {
      func_type                   func;
      logic signed [VALUE_W-1:0]  value;
   } req_type;

   typedef struct packed {
      status_type             status;
      logic                   found;
      logic [POS_OUT_W-1:0]   position;
      logic [CNT_OUT_W-1:0]   count;
   } rsp_type;

   // Control word sent to every cell of the chain.
   typedef struct packed {
      logic compare;     // register the match of this cell against the key
      logic in_use;      // cell holds a live entry
      logic load;        // take the key
      logic shift_up;    // take the entry of the lower-index neighbor
      logic shift_down;  // take the entry of the higher-index neighbor
   } cell_ctrl_type;

endpackage

>>> hw/rtl/bdsd_cell.sv
// ----------------------------------------------------------------------------
// bdsd_cell: one storage cell of the deque chain
// Holds one entry, compares it with the key and trades entries with its
// neighbors when the chain shifts.
// ----------------------------------------------------------------------------
module bdsd_cell
   import bdsd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cell_ctrl_type       ctrl,
   input  logic [VALUE_W-1:0]  key,
   input  logic [VALUE_W-1:0]  lower_data,
   input  logic [VALUE_W-1:0]  upper_data,
   output logic [VALUE_W-1:0]  data,
   output logic                hit
);

   logic [VALUE_W-1:0] data_ff;
   logic [VALUE_W-1:0] data_in;
   logic               hit_ff;
   logic               hit_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.load) begin
         data_in = key;
      end else if (ctrl.shift_up) begin
         data_in = lower_data;
      end else if (ctrl.shift_down) begin
         data_in = upper_data;
      end
   end

   // Hold the match flag until the next compare.
   assign hit_in = ctrl.compare ? (ctrl.in_use && (data_ff == key)) : hit_ff;

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   assign data = data_ff;
   assign hit  = hit_ff;

endmodule

>>> hw/rtl/bounded_deque_search_delete_unit.sv
// Each accepted transaction passes the compare state, where every cell registers
// its match, and the apply state, which registers the response and rsp_valid.
// A new transaction is taken only in idle, after the compare state and the apply
// state that each request walks through; busy covers both.
// Reset empties the store (count zero); entry contents are not cleared.
// The response strobe is not held: it lasts exactly one cycle.
// ----------------------------------------------------------------------------
// bounded_deque_search_delete_unit: ordered store with search and delete
// A chain of CAPACITY cells keeps entries in order from head (cell 0) to
// tail. Every request first compares all cells against the key in parallel,
// then picks the first match from the head and shifts the chain as needed.
// ----------------------------------------------------------------------------
module bounded_deque_search_delete_unit
   import bdsd_pkg::*;
#(
   parameter int CAPACITY = 16
)
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  req_type  req_data,
   output logic     rsp_valid,
   output rsp_type  rsp_data
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int POS_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_CMP   = 3'b010,
      S_APPLY = 3'b100
   } state_type;

   state_type            state_ff;
   state_type            state_in;
   func_type             func_ff;
   logic [VALUE_W-1:0]   key_ff;
   logic [CNT_W-1:0]     occ_ff;
   logic [CNT_W-1:0]     occ_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   rsp_type              rsp_ff;
   rsp_type              rsp_in;

   logic                 accept;
   logic [CAPACITY-1:0]  hit_vec;
   logic [CAPACITY-1:0]  hit_dec;
   logic [CAPACITY-1:0]  first_oh;
   logic [CAPACITY-1:0]  below_mask;
   logic                 any_hit;
   logic [POS_W-1:0]     first_pos;
   logic                 is_insert;
   logic                 full;
   logic                 do_head;
   logic                 do_tail;
   logic                 do_delete;
   logic [VALUE_W-1:0]   data_w [CAPACITY];
   cell_ctrl_type        ctrl_w [CAPACITY];

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);

   // Sequence each transaction through compare and apply.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (accept) state_in = S_CMP;
         S_CMP:   state_in = S_APPLY;
         S_APPLY: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the request; hold it while the chain works on it.
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_data.func;
         key_ff  <= req_data.value;
      end
      rsp_ff <= rsp_in;
   end

   // First match from the head: hit - 1 clears the lowest set bit and sets
   // every bit below it, so the bits below the first hit fall out directly.
   assign hit_dec    = hit_vec - CAPACITY'(1);
   assign below_mask = hit_dec & ~hit_vec;
   assign first_oh   = hit_vec & ~hit_dec;
   assign any_hit    = |hit_vec;

   always_comb begin
      first_pos = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (first_oh[i]) begin
            first_pos = first_pos | POS_W'(i);
         end
      end
   end

   assign is_insert = (func_ff == FN_INS_HEAD) || (func_ff == FN_INS_TAIL);
   assign full      = (occ_ff == CNT_W'(CAPACITY));
   assign do_head   = (state_ff == S_APPLY) && (func_ff == FN_INS_HEAD) && !full;
   assign do_tail   = (state_ff == S_APPLY) && (func_ff == FN_INS_TAIL) && !full;
   assign do_delete = (state_ff == S_APPLY) && (func_ff == FN_DELETE) && any_hit;

   // Advance the count and build the response in the apply cycle.
   always_comb begin
      logic [31:0] pos_ext;
      logic [31:0] cnt_ext;
      occ_in       = occ_ff;
      rsp_valid_in = (state_ff == S_APPLY);
      if (do_head || do_tail) begin
         occ_in = occ_ff + CNT_W'(1);
      end else if (do_delete) begin
         occ_in = occ_ff - CNT_W'(1);
      end
      pos_ext = 32'(first_pos);
      cnt_ext = 32'(occ_in);
      rsp_in.found    = 1'b0;
      rsp_in.position = '0;
      rsp_in.count    = cnt_ext[CNT_OUT_W-1:0];
      if (is_insert) begin
         rsp_in.status = full ? ST_FULL : ST_OK;
      end else if (occ_ff == '0) begin
         rsp_in.status = ST_EMPTY;
      end else if (!any_hit) begin
         rsp_in.status = ST_MISSING;
      end else begin
         rsp_in.status   = ST_OK;
         rsp_in.found    = 1'b1;
         rsp_in.position = pos_ext[POS_OUT_W-1:0];
      end
   end

   // The cell chain: head in cell 0, each cell trades with its neighbors.
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [VALUE_W-1:0] lower_w;
      logic [VALUE_W-1:0] upper_w;

      if (g == 0) begin : g_head
         assign lower_w = key_ff;
      end else begin : g_mid
         assign lower_w = data_w[g-1];
      end
      if (g == CAPACITY - 1) begin : g_tail
         assign upper_w = data_w[g];
      end else begin : g_up
         assign upper_w = data_w[g+1];
      end

      assign ctrl_w[g].compare    = (state_ff == S_CMP);
      assign ctrl_w[g].in_use     = (CNT_W'(g) < occ_ff);
      assign ctrl_w[g].load       = do_tail && (CNT_W'(g) == occ_ff);
      assign ctrl_w[g].shift_up   = do_head;
      assign ctrl_w[g].shift_down = do_delete && !below_mask[g];

      bdsd_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl_w[g]),
         .key        (key_ff),
         .lower_data (lower_w),
         .upper_data (upper_w),
         .data       (data_w[g]),
         .hit        (hit_vec[g])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The strobe lands after the transaction has left the chain.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response strobe while busy");

   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy not raised after accepted transaction");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CNT_W'(CAPACITY))
      else $error("occupancy beyond capacity");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.found) |-> (rsp_data.status == ST_OK))
      else $error("found flag without ok status");

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for bounded_deque_search_delete_unit
// Drives insert, delete and search transactions through the start/busy port,
// predicts every response with a queue-based model of the ordered store, and
// checks each strobed response field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
   import bdsd_pkg::*;

   localparam int CAPACITY     = 16;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   // Model of the store: head at index 0, tail at the back.
   logic signed [VALUE_W-1:0] store_model[$];
   // Predicted responses, oldest first.
   rsp_type pending_rsp[$];

   int error_count = 0;
   int cycle_count = 0;
   bit bursty = 1'b0;

   always #5 clock = ~clock;

   bounded_deque_search_delete_unit #(
      .CAPACITY(CAPACITY)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

   // Watchdog: end the run if it never drains.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(input string field, input int want, input int got);
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
   endtask

   // Compute the response of one request and update the store model.
   function automatic rsp_type predict_response(input req_type r);
      rsp_type res;
      int      hit;
      int      n;
      res        = '0;
      res.status = ST_OK;
      hit        = -1;
      if (r.func == FN_INS_HEAD || r.func == FN_INS_TAIL) begin
         if (store_model.size() >= CAPACITY)
            res.status = ST_FULL;
         else if (r.func == FN_INS_HEAD)
            store_model.push_front(r.value);
         else
            store_model.push_back(r.value);
      end else if (store_model.size() == 0) begin
         res.status = ST_EMPTY;
      end else begin
         // Only the first match from the head counts.
         foreach (store_model[i])
            if (hit < 0 && store_model[i] == r.value)
               hit = i;
         if (hit < 0) begin
            res.status = ST_MISSING;
         end else begin
            res.found    = 1'b1;
            res.position = hit[POS_OUT_W-1:0];
            if (r.func == FN_DELETE)
               store_model.delete(hit);
         end
      end
      n         = store_model.size();
      res.count = n[CNT_OUT_W-1:0];
      return res;
   endfunction

   // Check every strobed response; the receiver cannot stall, so take each one.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            error_count++;
            $display("%0t: unexpected response, expected none, actual %h", $time,
                     rsp_data);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.status !== want.status)
               report_mismatch("status", want.status, rsp_data.status);
            if (rsp_data.found !== want.found)
               report_mismatch("found", want.found, rsp_data.found);
            if (rsp_data.position !== want.position)
               report_mismatch("position", want.position, rsp_data.position);
            if (rsp_data.count !== want.count)
               report_mismatch("count", want.count, rsp_data.count);
         end
      end
   end

   // Send one transaction. Call and return at a falling edge; start stays high
   // afterwards so a back-to-back transaction keeps it up without a glitch.
   task automatic issue_request(input func_type f, input logic signed [VALUE_W-1:0] v);
      req_type r;
      int      gap;
      gap     = bursty ? 0 : $urandom_range(0, 14);
      r.func  = f;
      r.value = v;
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data = r;
      start    = 1'b1;
      // busy only moves at the rising edge, so its value here holds at the next one.
      while (busy) @(negedge clock);
      @(posedge clock);
      // Record the prediction before any response to it can be sampled.
      @(negedge clock);
      pending_rsp.push_back(predict_response(r));
   endtask

   // Hold the sender off until every predicted response has come back.
   task automatic wait_for_idle();
      start = 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value();
      // Favor a small pool so that matches and duplicates are common.
      if ($urandom_range(0, 9) < 4)
         return $urandom;
      case ($urandom_range(0, 7))
         0:       return 32'sh0000_0000;
         1:       return 32'sh0000_0001;
         2:       return -32'sd1;
         3:       return 32'sh7fff_ffff;
         4:       return 32'sh8000_0000;
         5:       return 32'sh5a5a_5a5a;
         6:       return 32'sha5a5_a5a5;
         default: return 32'sh0000_002a;
      endcase
   endfunction

   // Key for delete or search: mostly a live entry, else anything.
   function automatic logic signed [VALUE_W-1:0] pick_key();
      if (store_model.size() > 0 && $urandom_range(0, 3) != 0)
         return store_model[$urandom_range(0, store_model.size() - 1)];
      return pick_value();
   endfunction

   // Delete and search on the store right after reset.
   task automatic test_empty_store();
      issue_request(FN_DELETE, 32'sh0000_0000);
      issue_request(FN_SEARCH, 32'sh8000_0000);
      wait_for_idle();
   endtask

   // Fill to capacity from both ends with extreme values, then try to overfill.
   task automatic test_fill_to_capacity();
      logic signed [VALUE_W-1:0] v;
      for (int k = 0; k < CAPACITY - 1; k++) begin
         case (k % 5)
            0:       v = 32'sh8000_0000;
            1:       v = 32'sh7fff_ffff;
            2:       v = -32'sd1;
            3:       v = 32'sh0000_002a;
            default: v = $urandom;
         endcase
         issue_request((k % 2 == 0) ? FN_INS_HEAD : FN_INS_TAIL, v);
      end
      // The last tail entry lands at the highest position.
      issue_request(FN_INS_TAIL, 32'sh1234_5678);
      issue_request(FN_INS_HEAD, 32'sh0000_0000);
      issue_request(FN_INS_TAIL, -32'sd1);
   endtask

   // First-match rules on a full store with duplicates.
   task automatic test_match_rules();
      issue_request(FN_SEARCH, 32'sh1234_5678);
      issue_request(FN_SEARCH, 32'sh8000_0000);
      issue_request(FN_SEARCH, 32'sh0bad_0bad);
      issue_request(FN_DELETE, 32'sh7fff_ffff);
      issue_request(FN_DELETE, 32'sh0bad_0bad);
      issue_request(FN_SEARCH, 32'sh7fff_ffff);
   endtask

   // Random traffic that sweeps the store between empty and full.
   task automatic test_random_traffic(input int n_items);
      bit filling;
      int roll;
      filling = 1'b1;
      for (int k = 0; k < n_items; k++) begin
         // Alternate stretches of back-to-back traffic and random gaps.
         if (k % 40 == 0)
            bursty = ($urandom_range(0, 2) == 0);
         if (k > 0 && k % 90 == 0)
            wait_for_idle();
         if (store_model.size() >= CAPACITY)
            filling = 1'b0;
         else if (store_model.size() == 0)
            filling = 1'b1;
         roll = $urandom_range(0, 99);
         if (roll < (filling ? 65 : 20))
            issue_request($urandom_range(0, 1) ? FN_INS_TAIL : FN_INS_HEAD, pick_value());
         else if ($urandom_range(0, 4) < 3)
            issue_request(FN_DELETE, pick_key());
         else
            issue_request(FN_SEARCH, pick_key());
      end
      bursty = 1'b0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_store();
      test_fill_to_capacity();
      test_match_rules();
      test_random_traffic(375);

      // Drain, then give the pipeline time to show any stray strobe.
      wait_for_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
